// ----- rtl/generational_slot_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Generational slot allocator - assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define GSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gsa_pkg.sv -----
// ----------------------------------------------------------------------------
// gsa_pkg
// Types, constants and codes shared by the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int unsigned NUM_SLOTS   = 16;
  localparam int unsigned SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OUT_SLOT_W  = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // generation increment
  localparam logic [DATA_W-1:0] GEN_STEP = DATA_W'(1);

  // request kind codes
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PAYLOAD_LEN = 2'd0,
    CFG_MAX_TOTAL_BYTES = 2'd1,
    CFG_MAX_LIVE_COUNT  = 2'd2
  } cfg_idx_e;

  // classified operation
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_DROP
  } op_e;

  // back end sequencer
  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic [DATA_W-1:0] max_payload_len;
    logic [DATA_W-1:0] max_total_bytes;
    logic [DATA_W-1:0] max_live_count;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] owner;
    logic [DATA_W-1:0] len;
    logic [DATA_W-1:0] gen;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  // one slot table entry
  typedef struct packed {
    logic [DATA_W-1:0] gen;
    logic [DATA_W-1:0] owner;
    logic [DATA_W-1:0] size;
  } entry_t;

  // queue status toward the front end
  typedef struct packed {
    logic full;
  } q_stat_t;

endpackage

// ----- rtl/gsa_req_if.sv -----
// ----------------------------------------------------------------------------
// gsa_req_if
// Request channel: allocate or release items.
// ----------------------------------------------------------------------------
interface gsa_req_if
  import gsa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] owner;
  logic [DATA_W-1:0] req_length;
  logic [DATA_W-1:0] handle_slot;
  logic [DATA_W-1:0] handle_gen;

  modport source (output valid, kind, owner, req_length, handle_slot, handle_gen,
                  input ready);
  modport sink   (input valid, kind, owner, req_length, handle_slot, handle_gen,
                  output ready);
endinterface

// ----- rtl/gsa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gsa_rsp_if
// Result channel: one item per request.
// ----------------------------------------------------------------------------
interface gsa_rsp_if
  import gsa_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [OUT_SLOT_W-1:0] slot_index;
  logic [DATA_W-1:0]     slot_gen;

  modport source (output valid, ok, slot_index, slot_gen, input ready);
  modport sink   (input valid, ok, slot_index, slot_gen, output ready);
endinterface

// ----- rtl/gsa_cfg_if.sv -----
// ----------------------------------------------------------------------------
// gsa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gsa_cfg_if
  import gsa_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/gsa_ram.sv -----
// ----------------------------------------------------------------------------
// gsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ----- rtl/gsa_front.sv -----
// ----------------------------------------------------------------------------
// gsa_front
// Accepts request items and classifies them against the configuration:
// zero or oversize allocations and out-of-range releases become drops.
// ----------------------------------------------------------------------------
module gsa_front
  import gsa_pkg::*;
(
  input  cfg_t          cfg_i,
  gsa_req_if.sink       req_if,
  input  q_stat_t       q_stat_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  // accept whenever the queue has room
  assign req_if.ready = !q_stat_i.full;
  assign push_o       = req_if.valid && !q_stat_i.full;

  // classify
  always_comb begin
    cmd_o.owner = req_if.owner;
    cmd_o.len   = req_if.req_length;
    cmd_o.gen   = req_if.handle_gen;
    cmd_o.slot  = req_if.handle_slot[SLOT_W-1:0];
    if (req_if.kind == KIND_ALLOC) begin
      if ((req_if.req_length == '0) || (req_if.req_length > cfg_i.max_payload_len)) begin
        cmd_o.op = OP_DROP;
      end else begin
        cmd_o.op = OP_ALLOC;
      end
    end else begin
      if (req_if.handle_slot >= DATA_W'(NUM_SLOTS)) begin
        cmd_o.op = OP_DROP;
      end else begin
        cmd_o.op = OP_RELEASE;
      end
    end
  end
endmodule

// ----- rtl/gsa_queue.sv -----
// ----------------------------------------------------------------------------
// gsa_queue
// Short FIFO of classified commands between front and back end.
// ----------------------------------------------------------------------------
module gsa_queue
  import gsa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    data_i,
  output q_stat_t stat_o,
  input  logic    pop_i,
  output logic    valid_o,
  output cmd_t    data_o
);

  cmd_t                  buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wptr_q, wptr_d;
  logic [QPTR_W-1:0]     rptr_q, rptr_d;
  logic [QPTR_W:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign stat_o.full = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o     = (cnt_q != '0);
  assign data_o      = buf_q[rptr_q];
  assign do_push     = push_i && !stat_o.full;
  assign do_pop      = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= data_i;
    end
  end
endmodule

// ----- rtl/gsa_back.sv -----
// ----------------------------------------------------------------------------
// gsa_back
// Executes classified commands: quota check and lowest free slot pick,
// slot table read, then table and totals update with the result registered.
// ----------------------------------------------------------------------------
`include "generational_slot_allocator_unit_macros.svh"

module gsa_back
  import gsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  gsa_rsp_if.source rsp_if
);

  bk_state_e             state_q, state_d;
  cmd_t                  cur_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [NUM_SLOTS-1:0]  pinned_q;
  logic [NUM_SLOTS-1:0]  written_q;
  logic [DATA_W-1:0]     live_bytes_q;
  logic [DATA_W-1:0]     live_count_q;
  logic                  rd_vld_q;
  logic                  rsp_valid_q;
  logic                  res_ok_q;
  logic [OUT_SLOT_W-1:0] res_slot_q;
  logic [DATA_W-1:0]     res_gen_q;

  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic [DATA_W:0]       bytes_sum;
  logic                  quota_ok;
  logic                  can_take;
  logic                  go_exec;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic                  ram_we;
  entry_t                ram_rdata;
  entry_t                entry;
  entry_t                wr_entry;
  logic                  rel_match;
  logic                  rel_cover;

  // lowest unpinned slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!pinned_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // quota check at full precision
  assign bytes_sum = {1'b0, live_bytes_q} + {1'b0, cmd_i.len};
  assign quota_ok  = (bytes_sum <= {1'b0, cfg_i.max_total_bytes}) &&
                     (live_count_q < cfg_i.max_live_count) && free_found;

  // take a command only when the result register will be free
  assign can_take  = !rsp_valid_q || rsp_if.ready;
  assign cmd_pop_o = (state_q == BK_IDLE) && cmd_valid_i && can_take;
  assign go_exec   = cmd_pop_o &&
                     ((cmd_i.op == OP_RELEASE) || ((cmd_i.op == OP_ALLOC) && quota_ok));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (go_exec) state_d = BK_EXEC;
      BK_EXEC: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs: table access and update values
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = (cmd_i.op == OP_RELEASE) ? cmd_i.slot : free_idx;
    ram_we    = 1'b0;
    case (state_q)
      BK_IDLE: ram_re = go_exec;
      BK_EXEC: ram_we = (cur_q.op == OP_ALLOC);
      default: ram_re = 1'b0;
    endcase
  end

  // never-written entries read as zero
  assign entry = rd_vld_q ? ram_rdata : '0;

  always_comb begin
    wr_entry.gen   = entry.gen + GEN_STEP;
    wr_entry.owner = cur_q.owner;
    wr_entry.size  = (entry.size < cur_q.len) ? cur_q.len : entry.size;
  end

  assign rel_match = pinned_q[slot_q] && (entry.gen == cur_q.gen) &&
                     (entry.owner == cur_q.owner);
  assign rel_cover = (live_bytes_q >= entry.size);

  gsa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      pinned_q     <= '0;
      written_q    <= '0;
      live_bytes_q <= '0;
      live_count_q <= '0;
      rsp_valid_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_re) begin
        rd_vld_q <= written_q[ram_raddr];
      end
      if (state_q == BK_EXEC) begin
        rsp_valid_q <= 1'b1;
        if (cur_q.op == OP_ALLOC) begin
          pinned_q[slot_q]  <= 1'b1;
          written_q[slot_q] <= 1'b1;
          live_bytes_q      <= live_bytes_q + cur_q.len;
          live_count_q      <= live_count_q + GEN_STEP;
        end else if (rel_match) begin
          pinned_q[slot_q] <= 1'b0;
          if (rel_cover) begin
            live_bytes_q <= live_bytes_q - entry.size;
            live_count_q <= live_count_q - GEN_STEP;
          end
        end
      end else if (cmd_pop_o && !go_exec) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_if.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (go_exec) begin
      cur_q  <= cmd_i;
      slot_q <= ram_raddr;
    end
    if (state_q == BK_EXEC) begin
      if (cur_q.op == OP_ALLOC) begin
        res_ok_q   <= 1'b1;
        res_slot_q <= OUT_SLOT_W'(slot_q);
        res_gen_q  <= wr_entry.gen;
      end else begin
        res_ok_q   <= rel_match;
        res_slot_q <= '0;
        res_gen_q  <= '0;
      end
    end else if (cmd_pop_o && !go_exec) begin
      res_ok_q   <= 1'b0;
      res_slot_q <= '0;
      res_gen_q  <= '0;
    end
  end

  assign rsp_if.valid      = rsp_valid_q;
  assign rsp_if.ok         = res_ok_q;
  assign rsp_if.slot_index = res_slot_q;
  assign rsp_if.slot_gen   = res_gen_q;

  // checks
  `GSA_ASSERT_NOW(a_exec_out_free, state_q == BK_EXEC, !rsp_valid_q, "result register busy in exec")
  `GSA_ASSERT_NOW(a_alloc_slot_free, (state_q == BK_EXEC) && (cur_q.op == OP_ALLOC), !pinned_q[slot_q], "allocating a pinned slot")
  `GSA_ASSERT_NEXT(a_alloc_pins_one, (state_q == BK_EXEC) && (cur_q.op == OP_ALLOC), $countones(pinned_q) == $past($countones(pinned_q)) + 1, "grant did not pin exactly one slot")
endmodule

// ----- rtl/generational_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// generational_slot_allocator_unit
// Slot table handing out generation-tagged handles under byte and count
// quotas; holds the configuration registers and ties front, queue and back.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                        Handshake
//  req_if   in   kind, owner, req_length, handle_slot, handle_gen valid/ready
//  rsp_if   out  ok, slot_index, slot_gen                        valid/ready
//  cfg_if   in   index, data (register write)                   valid/ready
//
//  Back end: an item passes slot pick plus table read, then table and totals
//  update, with the result registered; items refused in classification or on
//  quota skip both steps and have their result registered when taken.
//  Reset: no clearing pass; per-slot valid bits make unwritten slots read 0.
//  Stalls: a 2-entry queue keeps taking items while the result waits.
// ----------------------------------------------------------------------------
module generational_slot_allocator_unit
  import gsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gsa_req_if.sink   req_if,
  gsa_rsp_if.source rsp_if,
  gsa_cfg_if.sink   cfg_if
);

  cfg_t    cfg_q;
  cmd_t    fr_cmd;
  cmd_t    q_cmd;
  logic    fr_push;
  logic    q_valid;
  logic    bk_pop;
  q_stat_t q_stat;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_idx_e'(cfg_if.index))
        CFG_MAX_PAYLOAD_LEN: cfg_q.max_payload_len <= cfg_if.data;
        CFG_MAX_TOTAL_BYTES: cfg_q.max_total_bytes <= cfg_if.data;
        CFG_MAX_LIVE_COUNT:  cfg_q.max_live_count  <= cfg_if.data;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  gsa_front u_front (
    .cfg_i    (cfg_q),
    .req_if   (req_if),
    .q_stat_i (q_stat),
    .push_o   (fr_push),
    .cmd_o    (fr_cmd)
  );

  gsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_cmd),
    .stat_o  (q_stat),
    .pop_i   (bk_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  gsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (bk_pop),
    .rsp_if      (rsp_if)
  );
endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and release items into the generational slot allocator and
// predicts every result from a private copy of the slot table, the live
// totals and the limit registers. A directed opening covers refusals, quota
// edges, handle mismatches and the undersized byte total; random phases under
// several limit settings follow, with random idling and one long result stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] owner;
    logic [DATA_W-1:0] req_length;
    logic [DATA_W-1:0] handle_slot;
    logic [DATA_W-1:0] handle_gen;
  } request_t;

  typedef struct packed {
    logic                  ok;
    logic [OUT_SLOT_W-1:0] slot_index;
    logic [DATA_W-1:0]     slot_gen;
  } grant_t;

  // Predicted slot table and the grants still owed by the block
  class slot_ledger;
    bit [DATA_W-1:0] gen_of   [NUM_SLOTS];
    bit [DATA_W-1:0] owner_of [NUM_SLOTS];
    bit [DATA_W-1:0] size_of  [NUM_SLOTS];
    bit              pinned   [NUM_SLOTS];
    bit [DATA_W-1:0] live_bytes;
    bit [DATA_W-1:0] live_count;
    bit [DATA_W-1:0] len_limit;
    bit [DATA_W-1:0] byte_quota;
    bit [DATA_W-1:0] count_quota;
    grant_t          owed[$];
    int unsigned     faults;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        gen_of[i]   = '0;
        owner_of[i] = '0;
        size_of[i]  = '0;
        pinned[i]   = 1'b0;
      end
      live_bytes  = '0;
      live_count  = '0;
      len_limit   = '0;
      byte_quota  = '0;
      count_quota = '0;
      faults      = 0;
    endfunction

    function void set_limit(cfg_idx_e idx, bit [DATA_W-1:0] value);
      case (idx)
        CFG_MAX_PAYLOAD_LEN: len_limit   = value;
        CFG_MAX_TOTAL_BYTES: byte_quota  = value;
        CFG_MAX_LIVE_COUNT:  count_quota = value;
        default: ;
      endcase
    endfunction

    // Accepted request: update the table and queue the grant it earns
    function void take_request(request_t r);
      grant_t          g;
      bit              found;
      bit [SLOT_W-1:0] s;
      g     = '0;
      found = 1'b0;
      if (r.kind == KIND_ALLOC) begin
        // quota sums are taken one bit wider so they cannot wrap
        if (r.req_length != '0 && r.req_length <= len_limit &&
            ({1'b0, live_bytes} + r.req_length) <= {1'b0, byte_quota} &&
            ({1'b0, live_count} + 33'd1) <= {1'b0, count_quota}) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && !pinned[i]) begin
              found = 1'b1;
              if (size_of[i] < r.req_length) size_of[i] = r.req_length;
              gen_of[i]    = gen_of[i] + GEN_STEP;
              owner_of[i]  = r.owner;
              pinned[i]    = 1'b1;
              live_bytes   = live_bytes + r.req_length;
              live_count   = live_count + 1;
              g.ok         = 1'b1;
              g.slot_index = OUT_SLOT_W'(i);
              g.slot_gen   = gen_of[i];
            end
          end
        end
      end else if (r.handle_slot < NUM_SLOTS) begin
        s = r.handle_slot[SLOT_W-1:0];
        if (gen_of[s] == r.handle_gen && owner_of[s] == r.owner && pinned[s]) begin
          pinned[s] = 1'b0;
          // totals only fall when the byte total covers the stored size
          if (live_bytes >= size_of[s]) begin
            live_bytes = live_bytes - size_of[s];
            live_count = live_count - 1;
          end
          g.ok = 1'b1;
        end
      end
      owed.push_back(g);
    endfunction

    function void note_fault(string what, grant_t want, grant_t got);
      faults++;
      if (faults <= 10)
        $display("[%0t] %s: ok %0b/%0b slot_index %0d/%0d slot_gen %h/%h (exp/act)",
                 $time, what, want.ok, got.ok, want.slot_index, got.slot_index,
                 want.slot_gen, got.slot_gen);
    endfunction

    // Accepted result: compare against the oldest owed grant
    function void match_grant(grant_t got);
      grant_t want;
      if (owed.size() == 0) begin
        note_fault("result with nothing outstanding", '0, got);
      end else begin
        want = owed.pop_front();
        if (got.ok !== want.ok || got.slot_index !== want.slot_index ||
            got.slot_gen !== want.slot_gen)
          note_fault("result mismatch", want, got);
      end
    endfunction
  endclass

  localparam bit [DATA_W-1:0] ALL_ONES    = '1;
  // byte backlog the directed part leaves behind for good
  localparam bit [DATA_W-1:0] BYTE_FLOOR  = 32'h1000_0000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gsa_req_if req_ch ();
  gsa_rsp_if rsp_ch ();
  gsa_cfg_if cfg_ch ();

  generational_slot_allocator_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_ch),
    .rsp_if (rsp_ch),
    .cfg_if (cfg_ch)
  );

  slot_ledger  ledger;
  bit          steady;
  bit          held;
  int unsigned hold_left;
  int unsigned grants_taken;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Request side monitor
  always @(posedge clk_i) begin
    if (rst_ni && req_ch.valid && req_ch.ready)
      ledger.take_request({req_ch.kind, req_ch.owner, req_ch.req_length,
                           req_ch.handle_slot, req_ch.handle_gen});
  end

  // Result side: check accepted items, drive ready with random and long stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        ledger.match_grant({rsp_ch.ok, rsp_ch.slot_index, rsp_ch.slot_gen});
        grants_taken++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (grants_taken == 200 && !held) begin
        // long hold-off so the block backs up and stalls its input
        held      = 1'b1;
        hold_left = 80;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  function automatic request_t make_request(logic kind, logic [DATA_W-1:0] owner,
                                            logic [DATA_W-1:0] len,
                                            logic [DATA_W-1:0] slot,
                                            logic [DATA_W-1:0] gen);
    request_t r;
    r.kind        = kind;
    r.owner       = owner;
    r.req_length  = len;
    r.handle_slot = slot;
    r.handle_gen  = gen;
    return r;
  endfunction

  // Random item, mostly well-formed: releases name live handles
  function automatic request_t random_request();
    request_t        r;
    int unsigned     live;
    int unsigned     s;
    int unsigned     p;
    bit [DATA_W-1:0] cap;
    live = 0;
    for (int i = 0; i < NUM_SLOTS; i++) live += ledger.pinned[i];
    r.owner       = $urandom();
    r.req_length  = $urandom();
    r.handle_slot = $urandom_range(NUM_SLOTS-1);
    r.handle_gen  = $urandom();
    if ($urandom_range(99) < ((live == 0) ? 15 : ((live >= 4) ? 60 : 40))) begin
      r.kind = KIND_RELEASE;
      s = $urandom_range(NUM_SLOTS-1);
      while (live != 0 && !ledger.pinned[s]) s = $urandom_range(NUM_SLOTS-1);
      r.handle_slot = s;
      r.handle_gen  = ledger.gen_of[s];
      r.owner       = ledger.owner_of[s];
      if ($urandom_range(99) < 25) begin
        p = $urandom_range(4);
        if (p == 0) begin
          r.handle_gen = r.handle_gen ^ (32'd1 << $urandom_range(31));
        end else if (p == 1) begin
          r.owner = $urandom();
        end else if (p == 2) begin
          r.handle_slot = $urandom();
        end else if (p == 3) begin
          r.handle_slot = NUM_SLOTS + $urandom_range(3);
        end else begin
          // any slot with its own handle: a repeat release if it is free
          s = $urandom_range(NUM_SLOTS-1);
          r.handle_slot = s;
          r.handle_gen  = ledger.gen_of[s];
          r.owner       = ledger.owner_of[s];
        end
      end
    end else begin
      r.kind = KIND_ALLOC;
      p   = $urandom_range(99);
      cap = (ledger.len_limit > 4096) ? 32'd4096 : ledger.len_limit;
      if (p < 5)
        r.req_length = '0;
      else if (p < 10)
        r.req_length = $urandom();
      else if (p < 15 && ledger.len_limit != ALL_ONES)
        r.req_length = ledger.len_limit + 1;
      else if (cap == 0)
        r.req_length = 32'd1;
      else
        r.req_length = $urandom_range(cap, 1);
    end
    return r;
  endfunction

  // Offer one item with an optional idle gap; returns at the accepting edge
  task automatic send_request(request_t r);
    while (!steady && $urandom_range(99) < 9) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= r.kind;
    req_ch.owner       <= r.owner;
    req_ch.req_length  <= r.req_length;
    req_ch.handle_slot <= r.handle_slot;
    req_ch.handle_gen  <= r.handle_gen;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Stop offering and wait until every owed grant has come back
  task automatic drain();
    int unsigned spin;
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    for (spin = 0; spin < 5000 && ledger.owed.size() != 0; spin++)
      @(posedge clk_i);
  endtask

  task automatic program_limits(bit [DATA_W-1:0] len_max, bit [DATA_W-1:0] byte_max,
                                bit [DATA_W-1:0] count_max);
    cfg_idx_e        idx [3];
    bit [DATA_W-1:0] val [3];
    idx = '{CFG_MAX_PAYLOAD_LEN, CFG_MAX_TOTAL_BYTES, CFG_MAX_LIVE_COUNT};
    val = '{len_max, byte_max, count_max};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk_i); while (!cfg_ch.ready);
      ledger.set_limit(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(bit [DATA_W-1:0] len_max, bit [DATA_W-1:0] byte_max,
                           bit [DATA_W-1:0] count_max, int unsigned items);
    program_limits(len_max, byte_max, count_max);
    repeat (items) send_request(random_request());
    drain();
  endtask

  initial begin
    ledger             = new();
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_ALLOC;
    req_ch.owner       = '0;
    req_ch.req_length  = '0;
    req_ch.handle_slot = '0;
    req_ch.handle_gen  = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_MAX_PAYLOAD_LEN;
    cfg_ch.data        = '0;
    steady             = 1'b0;
    held               = 1'b0;
    hold_left          = 0;
    grants_taken       = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Limits still at reset: everything is refused or ignored
    send_request(make_request(KIND_ALLOC, 32'd1, ALL_ONES, '0, '0));
    send_request(make_request(KIND_RELEASE, '0, '0, '0, '0));
    drain();

    // Directed: fill slots 0..14 with one byte each, then corner cases on 15
    program_limits(ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(make_request(KIND_ALLOC, 32'd2, '0, '0, '0));
    repeat (NUM_SLOTS - 1) send_request(make_request(KIND_ALLOC, $urandom(), 32'd1, '0, '0));
    send_request(make_request(KIND_ALLOC, ALL_ONES, 32'hFFFF_FFF0, '0, '0));
    // byte total sits at all ones: one more byte must not wrap through
    send_request(make_request(KIND_ALLOC, 32'd3, 32'd1, '0, '0));
    send_request(make_request(KIND_RELEASE, ALL_ONES, '0, 32'd15, 32'd2));
    send_request(make_request(KIND_RELEASE, '0, '0, 32'd15, 32'd1));
    send_request(make_request(KIND_RELEASE, ALL_ONES, '0, 32'd15, 32'd1));
    send_request(make_request(KIND_RELEASE, ALL_ONES, '0, 32'd15, 32'd1));
    // slot 15 keeps its large size, so this release leaves the totals alone
    send_request(make_request(KIND_ALLOC, 32'h5A5A_5A5A, BYTE_FLOOR, '0, '0));
    send_request(make_request(KIND_ALLOC, 32'd4, 32'd1, '0, '0));
    send_request(make_request(KIND_RELEASE, 32'h5A5A_5A5A, '0, 32'd15, 32'd2));
    send_request(make_request(KIND_RELEASE, '0, '0, ALL_ONES, 32'd1));
    send_request(make_request(KIND_RELEASE, '0, '0, NUM_SLOTS, 32'd1));
    drain();

    // Random phases; the byte backlog keeps later releases from leaking
    run_phase(32'd64, BYTE_FLOOR + 32'd400, 32'd6, 250);
    run_phase('0, '0, '0, 40);
    run_phase($urandom_range(4096, 1), BYTE_FLOOR + $urandom_range(20000, 100),
              $urandom_range(12, 1), 220);
    steady = 1'b1;
    run_phase(32'd255, ALL_ONES, 32'd3, 220);
    steady = 1'b0;
    run_phase(ALL_ONES, ALL_ONES, ALL_ONES, 220);

    repeat (10) @(posedge clk_i);
    if (ledger.faults == 0 && ledger.owed.size() == 0) begin
      $display("[generational_slot_allocator_unit] OK");
    end else begin
      $display("[generational_slot_allocator_unit] ERROR");
    end
    $finish;
  end

  // Run time guard
  initial begin
    #5_000_000;
    $display("[generational_slot_allocator_unit] ERROR");
    $finish;
  end

endmodule
